// ===== src/ffra_pkg.sv =====
// ----------------------------------------------------------------------------
// ffra_pkg: shared types and constants of the first-fit range allocator
// Holds field widths, default sizes, register reset values, operation, status and register codes.
// ----------------------------------------------------------------------------
package ffra_pkg;

    // Fixed field widths.
    localparam int SLOT_W  = 11;
    localparam int INDEX_W = 10;
    localparam int ADDR_W  = 48;
    localparam int CFG_W   = 48;
    localparam int CFGI_W  = 2;

    // Default sizing.
    localparam int DEF_MAX_SLOTS = 1024;
    localparam int DEF_MAX_GAPS  = 512;

    // Register reset values.
    localparam logic [SLOT_W-1:0] RST_CAPACITY = 11'd1024;
    localparam logic [SLOT_W-1:0] RST_STRIDE   = 11'd32;
    localparam logic [ADDR_W-1:0] RST_BASE     = 48'd0;

    // Operation codes.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Configuration register indexes.
    localparam logic [CFGI_W-1:0] CFG_CAPACITY = 2'd0;
    localparam logic [CFGI_W-1:0] CFG_STRIDE   = 2'd1;
    localparam logic [CFGI_W-1:0] CFG_BASE     = 2'd2;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_ALLOC   = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_FREED   = 2'd2
    } t_status;

endpackage

// ===== src/ffra_ram.sv =====
// ----------------------------------------------------------------------------
// ffra_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module ffra_ram #(
    parameter int WIDTH = 22,
    parameter int DEPTH = 512,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/first_fit_range_allocator_core.sv =====
// ----------------------------------------------------------------------------
// first_fit_range_allocator_core: first-fit slot range allocator
// Keeps a sorted table of free intervals in RAM. Allocate takes the low end
// of the first interval long enough; free inserts a run and merges it with
// touching or overlapping neighbours.
//
//   Channel  | Signals                                   | Direction
//   ---------+-------------------------------------------+----------
//   input    | i_in_valid, o_in_stall, opcode/count/start| in
//   output   | o_out_valid, i_out_stall, status/index/...| out
//   config   | i_cfg_we, i_cfg_index, i_cfg_wdata        | in
//
// One beat is handled at a time. Each table entry scanned is read and then
// checked, and each entry moved is read and then written, as the single RAM
// read port requires. After reset or a capacity write, entry zero is rebuilt
// while the input is stalled. A new beat is taken while a result waits in the
// output register; a stalled output holds the block at its last step.
// ----------------------------------------------------------------------------
module first_fit_range_allocator_core #(
    parameter int MAX_SLOTS = ffra_pkg::DEF_MAX_SLOTS,
    parameter int MAX_GAPS  = ffra_pkg::DEF_MAX_GAPS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ffra_pkg::CFGI_W-1:0]   i_cfg_index,
    input  logic [ffra_pkg::CFG_W-1:0]    i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_opcode,
    input  logic [ffra_pkg::SLOT_W-1:0]   i_count,
    input  logic [ffra_pkg::INDEX_W-1:0]  i_start_req,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [1:0]                    o_status,
    output logic [ffra_pkg::INDEX_W-1:0]  o_slot_index,
    output logic [ffra_pkg::ADDR_W-1:0]   o_slot_address,
    output logic [ffra_pkg::SLOT_W-1:0]   o_free_slots
);
    import ffra_pkg::*;

    localparam int AW  = (MAX_GAPS > 1) ? $clog2(MAX_GAPS) : 1;
    localparam int CW  = $clog2(MAX_GAPS + 1);
    localparam int EW  = 2 * SLOT_W;
    localparam int PW  = 2 * SLOT_W;

    typedef enum logic [3:0] {
        S_IDLE, S_AL_RD, S_AL_CK, S_FR_RD, S_FR_CK, S_FR_END,
        S_CP_RD, S_CP_WR, S_CP_END, S_MUL, S_FIN
    } t_state;

    t_state             r_state;
    logic               r_init;
    logic [SLOT_W-1:0]  r_capacity;
    logic [SLOT_W-1:0]  r_stride;
    logic [ADDR_W-1:0]  r_base;
    logic [CW-1:0]      r_gc;
    logic [CW-1:0]      r_gc_next;
    logic [SLOT_W-1:0]  r_free_total;
    logic [CW-1:0]      r_j;
    logic [CW-1:0]      r_lo;
    logic [CW-1:0]      r_dst;
    logic [CW-1:0]      r_src;
    logic               r_up;
    logic               r_phb;
    logic               r_alloc;
    logic [SLOT_W-1:0]  r_count;
    logic [SLOT_W-1:0]  r_s;
    logic [SLOT_W-1:0]  r_e;
    logic [SLOT_W-1:0]  r_nf;
    logic [SLOT_W-1:0]  r_nl;
    logic [SLOT_W-1:0]  r_msum;
    logic [SLOT_W-1:0]  r_start;
    logic [PW-1:0]      r_prod;
    t_status            r_status;
    logic               r_out_valid;
    logic [1:0]         r_o_status;
    logic [INDEX_W-1:0] r_o_index;
    logic [ADDR_W-1:0]  r_o_addr;
    logic [SLOT_W-1:0]  r_o_free;

    logic [SLOT_W-1:0]  span;
    logic [SLOT_W:0]    e_raw;
    logic [SLOT_W-1:0]  e_clip;
    logic [EW-1:0]      rdata;
    logic [SLOT_W-1:0]  d_first;
    logic [SLOT_W-1:0]  d_limit;
    logic [SLOT_W-1:0]  d_len;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [EW-1:0]      ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic               in_acc;
    logic               out_free;

    // Managed range is capacity clamped to the table's slot limit.
    always_comb begin
        if ({6'd0, r_capacity} > 17'(MAX_SLOTS)) begin
            span = SLOT_W'(MAX_SLOTS);
        end else begin
            span = r_capacity;
        end
    end

    // End of a freed run, clipped to the range.
    assign e_raw  = {2'b00, i_start_req} + {1'b0, i_count};
    assign e_clip = (e_raw > {1'b0, span}) ? span : e_raw[SLOT_W-1:0];

    assign d_first = rdata[SLOT_W-1:0];
    assign d_limit = rdata[EW-1:SLOT_W];
    assign d_len   = d_limit - d_first;

    assign o_in_stall = (r_state != S_IDLE) || r_init;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    // RAM port control.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_j[AW-1:0];
        ram_wdata = {r_nl, r_nf};
        ram_raddr = r_j[AW-1:0];
        case (r_state)
            S_IDLE: begin
                if (r_init) begin
                    ram_we    = 1'b1;
                    ram_waddr = '0;
                    ram_wdata = {span, {SLOT_W{1'b0}}};
                end
            end
            S_AL_CK: begin
                if (d_len >= r_count && d_len != r_count) begin
                    ram_we    = 1'b1;
                    ram_wdata = {d_limit, d_first + r_count};
                end
            end
            S_FR_END: begin
                if (r_j != r_lo) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_lo[AW-1:0];
                end
            end
            S_CP_RD: begin
                ram_raddr = r_src[AW-1:0];
            end
            S_CP_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_dst[AW-1:0];
                ram_wdata = rdata;
            end
            S_CP_END: begin
                if (r_up) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_lo[AW-1:0];
                end
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    ffra_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_GAPS),
        .AW    (AW)
    ) u_gap_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rdata)
    );

    // Control sequencer, table bookkeeping and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_init       <= 1'b1;
            r_capacity   <= RST_CAPACITY;
            r_stride     <= RST_STRIDE;
            r_base       <= RST_BASE;
            r_gc         <= '0;
            r_free_total <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            // The output register empties when taken and refills as an item ends.
            if (out_free) begin
                r_out_valid <= (r_state == S_FIN);
            end

            // Configuration writes are to arrive only while idle; the block does not enforce it.
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_CAPACITY: begin
                        r_capacity <= i_cfg_wdata[SLOT_W-1:0];
                        r_init     <= 1'b1;
                    end
                    CFG_STRIDE: r_stride <= i_cfg_wdata[SLOT_W-1:0];
                    CFG_BASE:   r_base   <= i_cfg_wdata[ADDR_W-1:0];
                    default:    r_base   <= r_base;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (r_init) begin
                        if (!(i_cfg_we && i_cfg_index == CFG_CAPACITY)) begin
                            r_init <= 1'b0;
                        end
                        r_free_total <= span;
                        r_gc         <= (span == '0) ? '0 : CW'(1);
                    end else if (in_acc) begin
                        r_alloc <= (i_opcode == OP_ALLOC);
                        r_count <= i_count;
                        r_start <= '0;
                        r_j     <= '0;
                        r_phb   <= 1'b0;
                        r_msum  <= '0;
                        r_s     <= {1'b0, i_start_req};
                        r_e     <= e_clip;
                        r_nf    <= {1'b0, i_start_req};
                        r_nl    <= e_clip;
                        if (i_opcode == OP_ALLOC) begin
                            if (i_count == '0 || i_count > r_free_total) begin
                                r_status <= ST_NOSPACE;
                                r_state  <= S_FIN;
                            end else begin
                                r_status <= ST_ALLOC;
                                r_state  <= S_AL_RD;
                            end
                        end else begin
                            r_status <= ST_FREED;
                            if ({1'b0, i_start_req} < e_clip) begin
                                r_state <= S_FR_RD;
                            end else begin
                                r_state <= S_FIN;
                            end
                        end
                    end
                end

                // First-fit scan: read one entry, then check it.
                S_AL_RD: begin
                    if (r_j == r_gc) begin
                        r_status <= ST_NOSPACE;
                        r_state  <= S_FIN;
                    end else begin
                        r_state <= S_AL_CK;
                    end
                end
                S_AL_CK: begin
                    if (d_len >= r_count) begin
                        r_start      <= d_first;
                        r_free_total <= r_free_total - r_count;
                        if (d_len == r_count) begin
                            r_up      <= 1'b0;
                            r_dst     <= r_j;
                            r_src     <= r_j + CW'(1);
                            r_gc_next <= r_gc - CW'(1);
                            r_state   <= S_CP_RD;
                        end else begin
                            r_state <= S_MUL;
                        end
                    end else begin
                        r_j     <= r_j + CW'(1);
                        r_state <= S_AL_RD;
                    end
                end

                // Free scan: skip entries wholly below, then merge touching ones.
                S_FR_RD: begin
                    if (r_j == r_gc) begin
                        if (!r_phb) begin
                            r_lo <= r_j;
                        end
                        r_state <= S_FR_END;
                    end else begin
                        r_state <= S_FR_CK;
                    end
                end
                S_FR_CK: begin
                    if (!r_phb && d_limit < r_s) begin
                        r_j     <= r_j + CW'(1);
                        r_state <= S_FR_RD;
                    end else begin
                        if (!r_phb) begin
                            r_phb <= 1'b1;
                            r_lo  <= r_j;
                        end
                        if (d_first <= r_e) begin
                            if (d_first < r_nf) r_nf <= d_first;
                            if (d_limit > r_nl) r_nl <= d_limit;
                            r_msum  <= r_msum + d_len;
                            r_j     <= r_j + CW'(1);
                            r_state <= S_FR_RD;
                        end else begin
                            r_state <= S_FR_END;
                        end
                    end
                end
                S_FR_END: begin
                    if (r_j == r_lo) begin
                        if (r_gc >= CW'(MAX_GAPS)) begin
                            r_state <= S_FIN;
                        end else begin
                            r_up         <= 1'b1;
                            r_dst        <= r_gc;
                            r_src        <= r_gc - CW'(1);
                            r_gc_next    <= r_gc + CW'(1);
                            r_free_total <= r_free_total + (r_nl - r_nf);
                            r_state      <= S_CP_RD;
                        end
                    end else begin
                        r_up         <= 1'b0;
                        r_dst        <= r_lo + CW'(1);
                        r_src        <= r_j;
                        r_gc_next    <= r_gc - (r_j - r_lo - CW'(1));
                        r_free_total <= r_free_total - r_msum + (r_nl - r_nf);
                        r_state      <= S_CP_RD;
                    end
                end

                // Table move: read the source entry, then write it to its new place.
                S_CP_RD: begin
                    if ((!r_up && r_src == r_gc) || (r_up && r_dst == r_lo)) begin
                        r_state <= S_CP_END;
                    end else begin
                        r_state <= S_CP_WR;
                    end
                end
                S_CP_WR: begin
                    if (r_up) begin
                        r_dst <= r_dst - CW'(1);
                        r_src <= r_src - CW'(1);
                    end else begin
                        r_dst <= r_dst + CW'(1);
                        r_src <= r_src + CW'(1);
                    end
                    r_state <= S_CP_RD;
                end
                S_CP_END: begin
                    r_gc    <= r_gc_next;
                    r_state <= r_alloc ? S_MUL : S_FIN;
                end

                // Slot offset product, added to the base on the way out.
                S_MUL: begin
                    r_prod  <= r_start * r_stride;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        r_o_status  <= r_status;
                        r_o_free    <= r_free_total;
                        if (r_status == ST_ALLOC) begin
                            r_o_index <= r_start[INDEX_W-1:0];
                            r_o_addr  <= r_base + {{(ADDR_W-PW){1'b0}}, r_prod};
                        end else begin
                            r_o_index <= '0;
                            r_o_addr  <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_o_status;
    assign o_slot_index   = r_o_index;
    assign o_slot_address = r_o_addr;
    assign o_free_slots   = r_o_free;

    // The table never holds more entries than the RAM has.
    a_gc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gc <= CW'(MAX_GAPS))
        else $error("gap count exceeds table depth");

    // An empty table means nothing is free.
    a_empty_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !r_init && r_gc == '0) |-> (r_free_total == '0))
        else $error("free total nonzero with empty table");

    // Free slots never exceed the managed range once rebuilt.
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !r_init) |-> (r_free_total <= span))
        else $error("free total exceeds range");

endmodule
